/* rtl/core/avbc_pkg.sv */
// ----------------------------------------------------------------------------
// avbc_pkg: shared types, constants and field arithmetic
// Holds the controller state type, the register indexes, the GF(2^8)
// helpers for the 0x14D field and the forward and inverse S-box tables.
// ----------------------------------------------------------------------------
package avbc_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [255:0][7:0] sbox_tbl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_START,
    ST_KEY0,
    ST_ROUND,
    ST_FINISH
  } state_t;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HI = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LO = 8'd1;

  // Low byte of the reduction polynomial x^8 + x^6 + x^3 + x^2 + 1.
  localparam byte_t FIELD_LOW = 8'h4D;
  localparam byte_t SBOX_ADD  = 8'h15;

  // Field multiply, shift-and-add with reduction.
  function automatic byte_t gf_mul(byte_t a, byte_t b);
    byte_t p;
    byte_t x;
    p = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = x[7] ? ({x[6:0], 1'b0} ^ FIELD_LOW) : {x[6:0], 1'b0};
    end
    return p;
  endfunction

  // Field inverse as a^254; zero maps to zero.
  function automatic byte_t gf_inv(byte_t a);
    byte_t r;
    byte_t base;
    logic [7:0] e;
    r = 8'h01;
    base = a;
    e = 8'd254;
    for (int i = 0; i < 8; i++) begin
      if (e[i]) r = gf_mul(r, base);
      base = gf_mul(base, base);
    end
    return r;
  endfunction

  function automatic byte_t rotl8(byte_t x, int n);
    logic [15:0] d;
    d = {x, x} << n;
    return d[15:8];
  endfunction

  // Table generators, evaluated at elaboration.
  function automatic sbox_tbl_t gen_sbox_fwd();
    sbox_tbl_t t;
    byte_t v;
    for (int i = 0; i < 256; i++) begin
      v = gf_inv(byte_t'(i));
      t[byte_t'(i)] = v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ SBOX_ADD;
    end
    return t;
  endfunction

  function automatic sbox_tbl_t gen_sbox_inv();
    sbox_tbl_t t;
    byte_t z;
    for (int i = 0; i < 256; i++) begin
      z = byte_t'(i) ^ SBOX_ADD;
      t[byte_t'(i)] = gf_inv(rotl8(z, 1) ^ rotl8(z, 3) ^ rotl8(z, 6));
    end
    return t;
  endfunction

  localparam sbox_tbl_t SBOX_FWD = gen_sbox_fwd();
  localparam sbox_tbl_t SBOX_INV = gen_sbox_inv();

  function automatic byte_t sub_fwd(byte_t x);
    return SBOX_FWD[x];
  endfunction

  function automatic byte_t sub_inv(byte_t x);
    return SBOX_INV[x];
  endfunction

  // Round constants for the key schedule.
  function automatic byte_t rcon(logic [3:0] idx);
    byte_t r;
    case (idx)
      4'd0:    r = 8'h01;
      4'd1:    r = 8'h02;
      4'd2:    r = 8'h04;
      4'd3:    r = 8'h08;
      4'd4:    r = 8'h10;
      4'd5:    r = 8'h20;
      4'd6:    r = 8'h40;
      4'd7:    r = 8'h80;
      4'd8:    r = 8'h4D;
      4'd9:    r = 8'h9A;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Column mix coefficients, rotated by row.
  function automatic byte_t mix_coef(logic dec, logic [1:0] idx);
    byte_t r;
    case (idx)
      2'd0:    r = dec ? 8'h0E : 8'h02;
      2'd1:    r = dec ? 8'h0B : 8'h03;
      2'd2:    r = dec ? 8'h0D : 8'h01;
      default: r = dec ? 8'h09 : 8'h01;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/aes_variant_block_cipher.sv */
// ----------------------------------------------------------------------------
// aes_variant_block_cipher: iterative AES-128 variant (field 0x14D)
// Encrypts or decrypts one 128-bit block per transaction with round keys
// held in an on-chip round key memory.
// ----------------------------------------------------------------------------
// Usage:
//   The key is written through the cfg_ channel (index 0 = key_hi,
//   index 1 = key_lo); the user must write it only while the block is
//   idle, which the block itself does not enforce; cfg_ready is always high.
//   Any key write marks the round keys stale. An input transaction
//   carries req_type (0 encrypt, 1 decrypt) and the block. If the round
//   keys are stale, they are expanded first, one round key per cycle
//   into the round key memory. With keys in place, a transaction goes
//   through the key memory read, the initial key add and one pass per
//   round through the single round unit. A new item is taken as soon
//   as the previous one has moved into the output register, so the
//   core never works on two blocks at once.
//   The result sits in an output register until out_ready; if the
//   previous result is still waiting, the finished block holds in the
//   core until the output register frees up.
//   Reset clears the key registers and the key-ready flag; the round key
//   memory needs no clearing since it is always filled before use.
// ----------------------------------------------------------------------------
module aes_variant_block_cipher
  import avbc_pkg::*;
#(
  parameter int unsigned NUM_ROUNDS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [63:0]          in_block_hi,
  input  logic [63:0]          in_block_lo,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          out_result_hi,
  output logic [63:0]          out_result_lo,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int unsigned RK_DEPTH = NUM_ROUNDS + 1;
  localparam int unsigned RK_AW    = $clog2(RK_DEPTH);
  localparam logic [RK_AW-1:0] LAST_RND = RK_AW'(NUM_ROUNDS);

  state_t            state_r, state_nxt;
  logic [63:0]       key_hi_r, key_lo_r;
  logic              keys_ready_r, keys_ready_nxt;
  logic [127:0]      s_r, s_nxt;
  logic              dec_r, dec_nxt;
  logic [RK_AW-1:0]  cnt_r, cnt_nxt;
  logic [127:0]      ek_r, ek_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [127:0]      out_data_r;

  logic [63:0]       rk_hi_mem [RK_DEPTH];
  logic [63:0]       rk_lo_mem [RK_DEPTH];
  logic [63:0]       rk_hi_q, rk_lo_q;
  logic [RK_AW-1:0]  rd_addr;
  logic              rk_we;

  logic [127:0]      round_out;
  logic              last_rnd;
  logic              out_free;
  logic              out_load;
  logic [127:0]      out_load_data;
  logic              cfg_wr;
  logic [31:0]       ek_t;
  logic [31:0]       ek_w0, ek_w1, ek_w2, ek_w3;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_result_hi = out_data_r[127:64];
  assign out_result_lo = out_data_r[63:0];

  assign last_rnd = (cnt_r == LAST_RND);
  assign out_free = !out_valid_r || out_ready;

  // Round datapath.
  avbc_round u_round (
    .state_i (s_r),
    .rkey_i  ({rk_hi_q, rk_lo_q}),
    .dec_i   (dec_r),
    .last_i  (last_rnd),
    .state_o (round_out)
  );

  // Key schedule step on the current round key.
  always_comb begin
    ek_t  = {sub_fwd(ek_r[23:16]) ^ rcon(4'(cnt_r)), sub_fwd(ek_r[15:8]),
             sub_fwd(ek_r[7:0]), sub_fwd(ek_r[31:24])};
    ek_w0 = ek_r[127:96] ^ ek_t;
    ek_w1 = ek_r[95:64] ^ ek_w0;
    ek_w2 = ek_r[63:32] ^ ek_w1;
    ek_w3 = ek_r[31:0] ^ ek_w2;
  end

  // Round key memory, one synchronous read port.
  always_ff @(posedge clk) begin
    if (rk_we) begin
      rk_hi_mem[cnt_r] <= ek_r[127:64];
      rk_lo_mem[cnt_r] <= ek_r[63:0];
    end
    rk_hi_q <= rk_hi_mem[rd_addr];
    rk_lo_q <= rk_lo_mem[rd_addr];
  end

  // Controller: next state, memory address and datapath updates.
  always_comb begin
    state_nxt      = state_r;
    keys_ready_nxt = keys_ready_r;
    s_nxt          = s_r;
    dec_nxt        = dec_r;
    cnt_nxt        = cnt_r;
    ek_nxt         = ek_r;
    rd_addr        = '0;
    rk_we          = 1'b0;
    out_load       = 1'b0;
    out_load_data  = s_r;
    unique case (state_r)
      ST_IDLE: begin
        rd_addr = in_req_type ? LAST_RND : '0;
        if (in_valid) begin
          s_nxt   = {in_block_hi, in_block_lo};
          dec_nxt = in_req_type;
          cnt_nxt = '0;
          ek_nxt  = {key_hi_r, key_lo_r};
          state_nxt = keys_ready_r ? ST_KEY0 : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        rk_we  = 1'b1;
        ek_nxt = {ek_w0, ek_w1, ek_w2, ek_w3};
        if (last_rnd) begin
          keys_ready_nxt = 1'b1;
          state_nxt      = ST_START;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_START: begin
        rd_addr   = dec_r ? LAST_RND : '0;
        state_nxt = ST_KEY0;
      end
      ST_KEY0: begin
        rd_addr   = dec_r ? LAST_RND - 1'b1 : RK_AW'(1);
        s_nxt     = s_r ^ {rk_hi_q, rk_lo_q};
        cnt_nxt   = RK_AW'(1);
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        rd_addr = last_rnd ? '0 : (dec_r ? LAST_RND - cnt_r - 1'b1 : cnt_r + 1'b1);
        s_nxt   = round_out;
        if (last_rnd) begin
          if (out_free) begin
            out_load      = 1'b1;
            out_load_data = round_out;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_FINISH;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // A key write makes the round keys stale.
    if (cfg_wr && (cfg_index == REG_KEY_HI || cfg_index == REG_KEY_LO)) begin
      keys_ready_nxt = 1'b0;
    end
  end

  // Output register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (out_load)  out_valid_nxt = 1'b1;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      keys_ready_r <= 1'b0;
      out_valid_r  <= 1'b0;
      key_hi_r     <= '0;
      key_lo_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      keys_ready_r <= keys_ready_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr && cfg_index == REG_KEY_HI) key_hi_r <= cfg_data;
      if (cfg_wr && cfg_index == REG_KEY_LO) key_lo_r <= cfg_data;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    s_r   <= s_nxt;
    dec_r <= dec_nxt;
    cnt_r <= cnt_nxt;
    ek_r  <= ek_nxt;
    if (out_load) out_data_r <= out_load_data;
  end

endmodule

/* rtl/core/avbc_round.sv */
// ----------------------------------------------------------------------------
// avbc_round: one cipher round
// Applies one forward or inverse round to the 128-bit state, with the
// column mix skipped in the last round.
// ----------------------------------------------------------------------------
module avbc_round
  import avbc_pkg::*;
(
  input  logic [127:0] state_i,
  input  logic [127:0] rkey_i,
  input  logic         dec_i,
  input  logic         last_i,
  output logic [127:0] state_o
);

  byte_t s   [16];
  byte_t k   [16];
  byte_t a   [16];
  byte_t b   [16];
  byte_t c   [16];
  byte_t m   [16];
  byte_t o   [16];
  byte_t acc;

  // Byte n of the block is row n%4, column n/4.
  always_comb begin
    acc = '0;
    for (int n = 0; n < 16; n++) begin
      s[n] = state_i[127-8*n -: 8];
      k[n] = rkey_i[127-8*n -: 8];
    end
    if (!dec_i) begin
      // Forward: substitute, shift rows, mix, add key.
      for (int n = 0; n < 16; n++) a[n] = sub_fwd(s[n]);
      for (int r = 0; r < 4; r++)
        for (int cc = 0; cc < 4; cc++)
          b[r+4*cc] = a[r+4*((cc+r)&3)];
      c = b;
    end else begin
      // Inverse: shift rows back, inverse substitute, add key.
      for (int r = 0; r < 4; r++)
        for (int cc = 0; cc < 4; cc++)
          a[r+4*cc] = s[r+4*((cc+4-r)&3)];
      for (int n = 0; n < 16; n++) b[n] = sub_inv(a[n]);
      for (int n = 0; n < 16; n++) c[n] = b[n] ^ k[n];
    end
    // Column mix on c.
    for (int cc = 0; cc < 4; cc++) begin
      for (int i = 0; i < 4; i++) begin
        acc = '0;
        for (int kk = 0; kk < 4; kk++)
          acc = acc ^ gf_mul(mix_coef(dec_i, 2'((kk - i) & 3)), c[4*cc+kk]);
        m[4*cc+i] = acc;
      end
    end
    for (int n = 0; n < 16; n++) begin
      if (!dec_i) o[n] = (last_i ? c[n] : m[n]) ^ k[n];
      else        o[n] = last_i ? c[n] : m[n];
    end
    for (int n = 0; n < 16; n++) state_o[127-8*n -: 8] = o[n];
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the AES-128 variant block cipher
// Drives encrypt and decrypt transactions under several keys, predicts each
// result with a behavioral cipher over the 0x14D field and compares it with
// the block output. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top
  import avbc_pkg::*;
;

  localparam int unsigned ROUNDS = 10;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  typedef struct packed {
    logic        op;
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_req_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_blk_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_req_type;
  logic [63:0] in_block_hi;
  logic [63:0] in_block_lo;
  logic out_valid;
  logic out_ready;
  logic [63:0] out_result_hi;
  logic [63:0] out_result_lo;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;

  aes_variant_block_cipher DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_block_hi(in_block_hi), .in_block_lo(in_block_lo),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_hi(out_result_hi), .out_result_lo(out_result_lo),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: key registers and the expanded schedule.
  logic [63:0] cur_key_hi, cur_key_lo;
  logic [7:0] sched [0:ROUNDS][0:15];
  bit sched_valid;

  cipher_req_t pending_reqs[$];
  cipher_blk_t expected_blocks[$];
  int errors;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] fmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = a[7] ? ({a[6:0], 1'b0} ^ 8'h4D) : {a[6:0], 1'b0};
    end
    return p;
  endfunction

  function automatic logic [7:0] finv(logic [7:0] a);
    logic [7:0] r, bse;
    r = 8'h01;
    bse = a;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = fmul(r, bse);
      bse = fmul(bse, bse);
    end
    return r;
  endfunction

  function automatic logic [7:0] rl(logic [7:0] x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox(logic [7:0] x);
    logic [7:0] v;
    v = finv(x);
    return v ^ rl(v, 1) ^ rl(v, 2) ^ rl(v, 3) ^ rl(v, 4) ^ 8'h15;
  endfunction

  function automatic logic [7:0] sbox_inv(logic [7:0] y);
    logic [7:0] z;
    z = y ^ 8'h15;
    return finv(rl(z, 1) ^ rl(z, 3) ^ rl(z, 6));
  endfunction

  // Key schedule from the current key registers.
  task automatic build_schedule();
    logic [7:0] k [0:15];
    logic [7:0] t [0:3];
    logic [7:0] rc;
    for (int n = 0; n < 8; n++) begin
      k[n] = cur_key_hi[63-8*n -: 8];
      k[n+8] = cur_key_lo[63-8*n -: 8];
    end
    for (int n = 0; n < 16; n++) sched[0][n] = k[n];
    rc = 8'h01;
    for (int r = 1; r <= ROUNDS; r++) begin
      t[0] = sbox(k[13]) ^ rc;
      t[1] = sbox(k[14]);
      t[2] = sbox(k[15]);
      t[3] = sbox(k[12]);
      for (int i = 0; i < 4; i++) k[i] ^= t[i];
      for (int c = 1; c < 4; c++)
        for (int i = 0; i < 4; i++) k[4*c+i] ^= k[4*(c-1)+i];
      for (int n = 0; n < 16; n++) sched[r][n] = k[n];
      rc = fmul(rc, 8'h02);
    end
    sched_valid = 1'b1;
  endtask

  // Full cipher or inverse cipher on one block.
  task automatic cipher_block(input cipher_req_t rq, output cipher_blk_t res);
    logic [7:0] s [0:15];
    logic [7:0] t [0:15];
    logic [7:0] acc;
    bit dec;
    if (!sched_valid) build_schedule();
    dec = (rq.op == OP_DEC);
    for (int n = 0; n < 8; n++) begin
      s[n] = rq.hi[63-8*n -: 8];
      s[n+8] = rq.lo[63-8*n -: 8];
    end
    for (int n = 0; n < 16; n++) s[n] ^= sched[dec ? ROUNDS : 0][n];
    for (int step = 1; step <= ROUNDS; step++) begin
      // Substitution and row shift commute, so order does not matter here.
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          t[r+4*c] = s[r + 4*(dec ? ((c + 4 - r) & 3) : ((c + r) & 3))];
      for (int n = 0; n < 16; n++) s[n] = dec ? sbox_inv(t[n]) : sbox(t[n]);
      if (dec) begin
        for (int n = 0; n < 16; n++) s[n] ^= sched[ROUNDS - step][n];
      end
      if (step != ROUNDS) begin
        for (int c = 0; c < 4; c++)
          for (int i = 0; i < 4; i++) begin
            acc = '0;
            for (int k = 0; k < 4; k++)
              acc ^= fmul(mix_coef(dec, 2'((k - i) & 3)), s[4*c+k]);
            t[4*c+i] = acc;
          end
        for (int n = 0; n < 16; n++) s[n] = t[n];
      end
      if (!dec) begin
        for (int n = 0; n < 16; n++) s[n] ^= sched[step][n];
      end
    end
    for (int n = 0; n < 8; n++) begin
      res.hi[63-8*n -: 8] = s[n];
      res.lo[63-8*n -: 8] = s[n+8];
    end
  endtask

  function automatic cipher_req_t rand_req();
    cipher_req_t rq;
    rq.op = 1'($urandom_range(0, 1));
    rq.hi = {$urandom, $urandom};
    rq.lo = {$urandom, $urandom};
    return rq;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Append one request to the pending queue.
  task automatic queue_req(input cipher_req_t rq);
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  // Key register write on the cfg channel.
  task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_KEY_HI) cur_key_hi = val;
    else if (idx == REG_KEY_LO) cur_key_lo = val;
    sched_valid = 1'b0;
  endtask

  // Wait until the block has drained all expected results.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_blocks.size() != 0)
      @(posedge clk);
    repeat (3 * ROUNDS) @(posedge clk);
  endtask

  // Driver: presents queued transactions with random gaps.
  int drv_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap = 0;
    end else begin
      cipher_req_t rq;
      cipher_blk_t res;
      bit busy;
      busy = in_valid;
      if (in_valid && in_ready) begin
        rq = pending_reqs.pop_front();
        cipher_block(rq, res);
        expected_blocks.insert(expected_blocks.size(), res);
        busy = 1'b0;
        drv_gap = gap_len();
      end
      if (!busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_valid <= 1'b1;
          in_req_type <= pending_reqs[0].op;
          in_block_hi <= pending_reqs[0].hi;
          in_block_lo <= pending_reqs[0].lo;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results and applies random back-pressure.
  int mon_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      mon_gap = 0;
      idle_cycles = 0;
    end else begin
      cipher_blk_t exp_blk;
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result hi=%h lo=%h", $time, out_result_hi, out_result_lo);
          errors++;
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (out_result_hi !== exp_blk.hi) begin
            $display("%0t: result_hi expected %h actual %h", $time, exp_blk.hi, out_result_hi);
            errors++;
          end
          if (out_result_lo !== exp_blk.lo) begin
            $display("%0t: result_lo expected %h actual %h", $time, exp_blk.lo, out_result_lo);
            errors++;
          end
        end
      end
      if (mon_gap > 0) begin
        mon_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) mon_gap = gap_len();
      end
    end
  end

  // Watchdog on transaction activity.
  always @(posedge clk) begin
    if (rst_n && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus and configuration phases.
  initial begin
    logic [63:0] kh, kl;
    cipher_req_t rq;
    errors = 0;
    sched_valid = 1'b0;
    cur_key_hi = '0;
    cur_key_lo = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = 1'b0;
    in_block_hi = '0;
    in_block_lo = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset key, then all-zero and all-one blocks both ways.
    queue_req('{OP_ENC, 64'h0, 64'h0});
    queue_req('{OP_DEC, 64'h0, 64'h0});
    queue_req('{OP_ENC, '1, '1});
    queue_req('{OP_DEC, '1, '1});
    drain();

    // Extreme keys, plus writes of an unused index which must not matter.
    write_key(REG_KEY_HI, '1);
    write_key(REG_KEY_LO, '1);
    write_key(CFG_IDX_W'(2), 64'h0123_4567_89AB_CDEF);
    write_key('1, 64'hDEAD_BEEF_0000_0000);
    queue_req('{OP_ENC, 64'h0, '1});
    queue_req('{OP_DEC, '1, 64'h0});
    queue_req('{OP_ENC, 64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF});
    queue_req('{OP_DEC, 64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF});
    drain();
    write_key(REG_KEY_HI, 64'h0);
    queue_req('{OP_ENC, 64'h8000_0000_0000_0000, 64'h1});
    queue_req('{OP_DEC, 64'h1, 64'h8000_0000_0000_0000});
    drain();
    write_key(REG_KEY_LO, 64'h0);
    queue_req('{OP_ENC, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA});
    queue_req('{OP_DEC, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555});
    drain();

    // Random phases, each under a fresh key; the same key written twice once.
    for (int ph = 0; ph < 8; ph++) begin
      kh = {$urandom, $urandom};
      kl = {$urandom, $urandom};
      write_key(REG_KEY_HI, kh);
      write_key(REG_KEY_LO, kl);
      if (ph == 3) write_key(REG_KEY_LO, kl);
      for (int i = 0; i < 105; i++) begin
        rq = rand_req();
        queue_req(rq);
      end
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* aes_variant_block_cipher.f */
rtl/core/avbc_pkg.sv
rtl/core/avbc_round.sv
rtl/core/aes_variant_block_cipher.sv
tb/tb_top.sv
